/* hw/rtl/eafs_pkg.sv */
// ----------------------------------------------------------------------------
// eafs_pkg
// Types and constants shared by the EIR advertising-data field scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package eafs_pkg;

  // Record length cap; lengths above it saturate.
  localparam int MAX_RECORD_BYTES = 255;
  localparam logic [7:0] REC_LEN_CAP = 8'(MAX_RECORD_BYTES);

  // AD type codes
  localparam logic [7:0] AD_NAME_FULL  = 8'h09;
  localparam logic [7:0] AD_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_FLAGS      = 8'h01;

  // Result kinds
  localparam logic RK_NAME    = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // Result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = RQ_PTR_W + 1;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_TYPE   = 2'd1,
    PH_DATA   = 2'd2
  } eafs_phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_FLAGS = 2'd2
  } eafs_kind_t;

  typedef enum logic [1:0] {
    NS_UNSEEN = 2'd0,
    NS_EMIT   = 2'd1,
    NS_DONE   = 2'd2
  } eafs_name_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic [7:0] record_length;
  } eafs_in_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] name_byte;
    logic       name_found;
    logic [7:0] name_length;
    logic       flags_found;
    logic [7:0] flags_value;
    logic       result_last;
  } eafs_out_t;

  // Results produced by one accepted byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    eafs_out_t  word0;
    eafs_out_t  word1;
  } eafs_push_t;

endpackage

`default_nettype wire

/* hw/rtl/eafs_core.sv */
// ----------------------------------------------------------------------------
// eafs_core
// Per-byte scan state and result generation for one accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module eafs_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire eafs_pkg::eafs_in_t  in_word,
  output eafs_pkg::eafs_push_t     push
);

  logic [7:0]                 byte_position, byte_position_next;
  logic [7:0]                 total_length, total_length_next;
  eafs_pkg::eafs_phase_t      field_phase, field_phase_next;
  logic [7:0]                 field_bytes_left, field_bytes_left_next;
  eafs_pkg::eafs_kind_t       field_kind, field_kind_next;
  logic                       scan_stopped, scan_stopped_next;
  eafs_pkg::eafs_name_state_t name_state, name_state_next;
  logic [7:0]                 name_count, name_count_next;
  logic                       flags_have, flags_have_next;
  logic [7:0]                 flags_byte, flags_byte_next;

  logic       emit;
  logic       summary;
  logic [7:0] b;

  assign b = in_word.data_byte;

  always_comb begin
    logic [9:0] nh;
    nh = '0;
    byte_position_next    = byte_position;
    total_length_next     = total_length;
    field_phase_next      = field_phase;
    field_bytes_left_next = field_bytes_left;
    field_kind_next       = field_kind;
    scan_stopped_next     = scan_stopped;
    name_state_next       = name_state;
    name_count_next       = name_count;
    flags_have_next       = flags_have;
    flags_byte_next       = flags_byte;
    emit                  = 1'b0;
    summary               = 1'b0;

    if (fire) begin
      if (in_word.first) begin
        byte_position_next    = '0;
        field_phase_next      = eafs_pkg::PH_LENGTH;
        field_bytes_left_next = '0;
        field_kind_next       = eafs_pkg::KIND_NONE;
        name_state_next       = eafs_pkg::NS_UNSEEN;
        name_count_next       = '0;
        flags_have_next       = 1'b0;
        flags_byte_next       = '0;
        total_length_next     = (in_word.record_length > eafs_pkg::REC_LEN_CAP) ?
                                eafs_pkg::REC_LEN_CAP : in_word.record_length;
        scan_stopped_next     = total_length_next < 8'd2;
      end

      if (in_word.first && total_length_next == 8'd0) begin
        // empty record: summary right away, byte not part of the record
        summary = 1'b1;
      end else if (byte_position_next < total_length_next) begin
        if (!scan_stopped_next) begin
          case (field_phase_next)
            eafs_pkg::PH_TYPE: begin
              if ((b inside {eafs_pkg::AD_NAME_FULL, eafs_pkg::AD_NAME_SHORT}) &&
                  name_state_next == eafs_pkg::NS_UNSEEN) begin
                field_kind_next = eafs_pkg::KIND_NAME;
                name_state_next = (field_bytes_left_next == 8'd0) ?
                                  eafs_pkg::NS_DONE : eafs_pkg::NS_EMIT;
              end else if (b == eafs_pkg::AD_FLAGS && field_bytes_left_next != 8'd0 &&
                           !flags_have_next) begin
                field_kind_next = eafs_pkg::KIND_FLAGS;
              end else begin
                field_kind_next = eafs_pkg::KIND_NONE;
              end
              field_phase_next = (field_bytes_left_next == 8'd0) ?
                                 eafs_pkg::PH_LENGTH : eafs_pkg::PH_DATA;
            end
            eafs_pkg::PH_DATA: begin
              if (field_bytes_left_next != 8'd0) begin
                field_bytes_left_next = field_bytes_left_next - 8'd1;
              end
              if (field_kind_next == eafs_pkg::KIND_NAME &&
                  name_state_next == eafs_pkg::NS_EMIT) begin
                if (b == 8'd0) begin
                  name_state_next = eafs_pkg::NS_DONE;
                end else begin
                  emit            = 1'b1;
                  name_count_next = name_count_next + 8'd1;
                end
              end else if (field_kind_next == eafs_pkg::KIND_FLAGS && !flags_have_next) begin
                flags_have_next = 1'b1;
                flags_byte_next = b;
              end
              if (field_bytes_left_next == 8'd0) begin
                if (field_kind_next == eafs_pkg::KIND_NAME &&
                    name_state_next == eafs_pkg::NS_EMIT) begin
                  name_state_next = eafs_pkg::NS_DONE;
                end
                field_kind_next  = eafs_pkg::KIND_NONE;
                field_phase_next = eafs_pkg::PH_LENGTH;
              end
            end
            default: begin
              // length byte; the unused phase code lands here too
              field_phase_next = eafs_pkg::PH_LENGTH;
              if ({1'b0, byte_position_next} + 9'd1 >= {1'b0, total_length_next} ||
                  b == 8'd0) begin
                scan_stopped_next = 1'b1;
              end else begin
                nh = {2'b00, byte_position_next} + {2'b00, b} + 10'd1;
                if (nh > {2'b00, total_length_next}) begin
                  scan_stopped_next = 1'b1;
                end else begin
                  field_bytes_left_next = b - 8'd1;
                  field_kind_next       = eafs_pkg::KIND_NONE;
                  field_phase_next      = eafs_pkg::PH_TYPE;
                end
              end
            end
          endcase
        end
        byte_position_next = byte_position_next + 8'd1;
        summary = (byte_position_next == total_length_next);
      end
    end
  end

  // Result words
  always_comb begin
    eafs_pkg::eafs_out_t name_w;
    eafs_pkg::eafs_out_t sum_w;
    name_w             = '0;
    name_w.result_kind = eafs_pkg::RK_NAME;
    name_w.name_byte   = b;
    name_w.result_last = !summary;

    sum_w             = '0;
    sum_w.result_kind = eafs_pkg::RK_SUMMARY;
    sum_w.name_found  = (name_state_next != eafs_pkg::NS_UNSEEN);
    sum_w.name_length = name_count_next;
    sum_w.flags_found = flags_have_next;
    sum_w.flags_value = flags_have_next ? flags_byte_next : 8'd0;
    sum_w.result_last = 1'b1;

    push = '0;
    if (emit) begin
      push.word0 = name_w;
      if (summary) begin
        push.word1 = sum_w;
        push.count = 2'd2;
      end else begin
        push.count = 2'd1;
      end
    end else if (summary) begin
      push.word0 = sum_w;
      push.count = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      total_length     <= '0;
      field_phase      <= eafs_pkg::PH_LENGTH;
      field_bytes_left <= '0;
      field_kind       <= eafs_pkg::KIND_NONE;
      scan_stopped     <= 1'b0;
      name_state       <= eafs_pkg::NS_UNSEEN;
      name_count       <= '0;
      flags_have       <= 1'b0;
      flags_byte       <= '0;
    end else begin
      byte_position    <= byte_position_next;
      total_length     <= total_length_next;
      field_phase      <= field_phase_next;
      field_bytes_left <= field_bytes_left_next;
      field_kind       <= field_kind_next;
      scan_stopped     <= scan_stopped_next;
      name_state       <= name_state_next;
      name_count       <= name_count_next;
      flags_have       <= flags_have_next;
      flags_byte       <= flags_byte_next;
    end
  end

  // Name byte always precedes the summary when one byte gives two words.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |->
      push.word0.result_kind == eafs_pkg::RK_NAME && !push.word0.result_last &&
      push.word1.result_kind == eafs_pkg::RK_SUMMARY && push.word1.result_last)
    else $error("eafs_core: bad result pair");

  a_push_on_fire: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> fire)
    else $error("eafs_core: result without accepted byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= total_length)
    else $error("eafs_core: position past record end");

endmodule

`default_nettype wire

/* hw/rtl/eafs_result_queue.sv */
// ----------------------------------------------------------------------------
// eafs_result_queue
// Small result queue: takes up to two words a cycle, delivers one while result_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module eafs_result_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire eafs_pkg::eafs_push_t push,
  output logic                      space_ok,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output eafs_pkg::eafs_out_t       result_word
);

  eafs_pkg::eafs_out_t              mem [eafs_pkg::RQ_DEPTH];
  logic [eafs_pkg::RQ_PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [eafs_pkg::RQ_PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [eafs_pkg::RQ_CNT_W-1:0]    count, count_next;
  logic                             pop;

  assign result_valid = (count != '0);
  assign result_word  = mem[rd_ptr];
  assign pop          = result_valid && result_ready;
  // room for a full pair of words
  assign space_ok     = (count <= eafs_pkg::RQ_CNT_W'(eafs_pkg::RQ_DEPTH - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + eafs_pkg::RQ_PTR_W'(push.count);
    rd_ptr_next = rd_ptr + eafs_pkg::RQ_PTR_W'(pop);
    count_next  = count + eafs_pkg::RQ_CNT_W'(push.count) - eafs_pkg::RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.word0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + eafs_pkg::RQ_PTR_W'(1)] <= push.word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= eafs_pkg::RQ_CNT_W'(eafs_pkg::RQ_DEPTH))
    else $error("eafs_result_queue: overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> space_ok)
    else $error("eafs_result_queue: push without room");

endmodule

`default_nettype wire

/* hw/rtl/eir_ad_field_scanner.sv */
// ----------------------------------------------------------------------------
// eir_ad_field_scanner
// Scans EIR records byte by byte; streams the name and gives a summary.
// ----------------------------------------------------------------------------
// Each result word enters the result queue at the clock edge that accepts the byte that caused it.
// Throughput: one byte per cycle while byte_ready is high; a byte giving name byte
//   plus summary puts two words on the result port, absorbed by a 4-word queue.
// byte_ready is high while the result queue has room for two words.
// Reset (rst, synchronous): clears scan state and empties the result queue.
`default_nettype none

module eir_ad_field_scanner (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_ready,
  input  wire eafs_pkg::eafs_in_t  byte_word,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output eafs_pkg::eafs_out_t      result_word
);

  eafs_pkg::eafs_push_t push;
  logic                 fire;

  assign fire = byte_valid && byte_ready;

  eafs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_word (byte_word),
    .push    (push)
  );

  eafs_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .space_ok     (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

endmodule

`default_nettype wire

/* verif/eafs_scan_checker.sv */
// ----------------------------------------------------------------------------
// eafs_scan_checker
// Watches both channels of the EIR field scanner, keeps its own copy of
// the scan state, works out the result words each accepted byte should
// give and compares every delivered word in order against them.
// ----------------------------------------------------------------------------
module eafs_scan_checker
  import eafs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  logic      byte_ready,
  input  eafs_in_t  byte_word,
  input  logic      result_valid,
  input  logic      result_ready,
  input  eafs_out_t result_word,
  output int        fail_count,
  output int        pending
);

  // scan state
  bit [7:0]         rec_pos;
  bit [7:0]         rec_total;
  eafs_phase_t      phase;
  bit [7:0]         field_left;
  eafs_kind_t       field_kind;
  bit               stopped;
  eafs_name_state_t name_st;
  bit [7:0]         name_cnt;
  bit               flags_seen;
  bit [7:0]         flags_val;

  eafs_out_t scan_results[$];
  int n_bad = 0;
  int n_wait = 0;

  assign fail_count = n_bad;
  assign pending    = n_wait;

  function automatic void clear_scan();
    rec_pos    = '0;
    rec_total  = '0;
    phase      = PH_LENGTH;
    field_left = '0;
    field_kind = KIND_NONE;
    stopped    = 1'b0;
    name_st    = NS_UNSEEN;
    name_cnt   = '0;
    flags_seen = 1'b0;
    flags_val  = '0;
  endfunction

  function automatic eafs_out_t summary_word();
    eafs_out_t s;
    s = '0;
    s.result_kind = RK_SUMMARY;
    s.name_found  = (name_st != NS_UNSEEN);
    s.name_length = name_cnt;
    s.flags_found = flags_seen;
    s.flags_value = flags_seen ? flags_val : 8'h00;
    s.result_last = 1'b1;
    return s;
  endfunction

  // Advance the scan by one accepted byte and queue the words it gives.
  task automatic take_byte(input eafs_in_t w);
    eafs_out_t nb;
    bit        emitted;
    bit [7:0]  b;
    b       = w.data_byte;
    emitted = 1'b0;
    nb      = '0;
    if (w.first) begin
      clear_scan();
      rec_total = (w.record_length > REC_LEN_CAP) ? REC_LEN_CAP : w.record_length;
      stopped   = (rec_total < 2);
      if (rec_total == 0) begin
        scan_results.push_back(summary_word());
        return;
      end
    end
    if (rec_pos >= rec_total) return;   // outside any record

    if (!stopped) begin
      case (phase)
        PH_TYPE: begin
          if ((b == AD_NAME_FULL || b == AD_NAME_SHORT) && name_st == NS_UNSEEN) begin
            field_kind = KIND_NAME;
            name_st    = (field_left == 0) ? NS_DONE : NS_EMIT;
          end else if (b == AD_FLAGS && field_left != 0 && !flags_seen) begin
            field_kind = KIND_FLAGS;
          end else begin
            field_kind = KIND_NONE;
          end
          phase = (field_left == 0) ? PH_LENGTH : PH_DATA;
        end
        PH_DATA: begin
          if (field_left != 0) field_left--;
          if (field_kind == KIND_NAME && name_st == NS_EMIT) begin
            if (b == 8'h00) begin
              name_st = NS_DONE;
            end else begin
              emitted        = 1'b1;
              nb.result_kind = RK_NAME;
              nb.name_byte   = b;
              name_cnt++;
            end
          end else if (field_kind == KIND_FLAGS && !flags_seen) begin
            flags_seen = 1'b1;
            flags_val  = b;
          end
          if (field_left == 0) begin
            if (field_kind == KIND_NAME && name_st == NS_EMIT) name_st = NS_DONE;
            field_kind = KIND_NONE;
            phase      = PH_LENGTH;
          end
        end
        default: begin
          // length byte; also where a stray phase code lands
          phase = PH_LENGTH;
          if (int'(rec_pos) + 1 >= int'(rec_total) || b == 8'h00) begin
            stopped = 1'b1;
          end else if (int'(rec_pos) + int'(b) + 1 > int'(rec_total)) begin
            stopped = 1'b1;
          end else begin
            field_left = b - 8'd1;
            field_kind = KIND_NONE;
            phase      = PH_TYPE;
          end
        end
      endcase
    end

    rec_pos++;
    if (emitted) begin
      nb.result_last = (rec_pos != rec_total);
      scan_results.push_back(nb);
    end
    if (rec_pos == rec_total) scan_results.push_back(summary_word());
  endtask

  task automatic compare_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin : watch
    eafs_out_t want;
    if (rst) begin
      clear_scan();
      scan_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (scan_results.size() == 0) begin
          $error("result word %h with nothing expected", result_word);
          n_bad++;
        end else begin
          want = scan_results.pop_front();
          compare_field("result_kind", want.result_kind, result_word.result_kind);
          compare_field("name_byte",   want.name_byte,   result_word.name_byte);
          compare_field("name_found",  want.name_found,  result_word.name_found);
          compare_field("name_length", want.name_length, result_word.name_length);
          compare_field("flags_found", want.flags_found, result_word.flags_found);
          compare_field("flags_value", want.flags_value, result_word.flags_value);
          compare_field("result_last", want.result_last, result_word.result_last);
        end
      end
      if (byte_valid && byte_ready) take_byte(byte_word);
    end
    n_wait = scan_results.size();
  end

endmodule

/* verif/tb_eir_ad_field_scanner.sv */
// ----------------------------------------------------------------------------
// tb_eir_ad_field_scanner
// Feeds the EIR field scanner a few hand-built records, then random records
// (mostly well formed, some cut short, corrupted or surrounded by stray
// bytes) with random gaps and result stalls; a checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_eir_ad_field_scanner;
  import eafs_pkg::*;

  localparam int RANDOM_BYTES = 700;
  localparam int CYCLE_LIMIT  = 800000;

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_ready;
  eafs_in_t  byte_word;
  logic      result_valid;
  logic      result_ready;
  eafs_out_t result_word;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int record_bytes = 0;
  bit byte_burst = 1'b0;
  bit drain = 1'b0;
  bit [7:0] rec_bytes[$];

  eir_ad_field_scanner dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_word   (byte_word),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_word (result_word)
  );

  eafs_scan_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_word   (byte_word),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_word (result_word),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure; the stall rate drifts between phases
  initial begin : result_sink
    int stall_left;
    int stall_pct;
    int n;
    stall_left = 0;
    stall_pct  = 10;
    n = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      n++;
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      if (drain) begin
        result_ready <= 1'b1;
      end else if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = gap_len() + 1;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_byte(input bit [7:0] d, input bit f, input bit [7:0] len);
    eafs_in_t w;
    int g;
    w.data_byte     = d;
    w.first         = f;
    w.record_length = len;
    byte_word  <= w;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    @(negedge clk);
    g = byte_burst ? 0 : gap_len();
    if (g > 0) begin
      byte_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // sends the first n bytes of a record of length len from rec_bytes
  task automatic send_record(input int len, input int n);
    bit [7:0] d;
    for (int i = 0; i < n; i++) begin
      d = (i < rec_bytes.size()) ? rec_bytes[i] : 8'($urandom);
      send_byte(d, i == 0, (i == 0) ? 8'(len) : 8'($urandom));
      record_bytes++;
    end
  endtask

  // well-formed length/type/data fields filling len bytes; a single leftover byte is random
  task automatic fill_record(input int len);
    int room;
    int flen;
    int ftype;
    bit [7:0] tcode;
    rec_bytes.delete();
    while (rec_bytes.size() < len) begin
      room = len - rec_bytes.size();
      if (room < 2) begin
        rec_bytes.push_back(8'($urandom));
        continue;
      end
      if ($urandom_range(0, 7) == 0) flen = $urandom_range(1, room - 1);
      else flen = $urandom_range(1, (room - 1 < 12) ? room - 1 : 12);
      ftype = $urandom_range(0, 9);
      tcode = (ftype < 2) ? AD_NAME_FULL : (ftype < 3) ? AD_NAME_SHORT :
              (ftype < 5) ? AD_FLAGS : 8'($urandom);
      rec_bytes.push_back(8'(flen));
      rec_bytes.push_back(tcode);
      repeat (flen - 1) begin
        if (ftype < 3)
          rec_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'h00 :
                              8'($urandom_range(8'h20, 8'h7e)));
        else
          rec_bytes.push_back(8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int len;
    int n;
    int r;
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_word  = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // stray byte, empty record, one-byte record
    send_byte(8'h5A, 1'b0, 8'h00);
    send_byte(8'hFF, 1'b1, 8'h00);
    send_byte(8'h02, 1'b1, 8'h01);
    // flags field, then a name cut by NUL
    rec_bytes = {8'h02, AD_FLAGS, 8'hA5, 8'h04, AD_NAME_FULL, 8'h41, 8'h00, 8'h42};
    send_record(8, 8);
    // empty short name, flags field with no data, then real flags
    rec_bytes = {8'h01, AD_NAME_SHORT, 8'h01, AD_FLAGS, 8'h02, AD_FLAGS, 8'hFF};
    send_record(7, 7);
    // record abandoned mid-name, then a name ending on the last byte
    rec_bytes = {8'h05, AD_NAME_FULL, 8'h61};
    send_record(10, 3);
    rec_bytes = {8'h03, AD_NAME_FULL, 8'h78, 8'h79};
    send_record(4, 4);

    // full-size record once, then random mix
    fill_record(255);
    send_record(255, 255);
    while (record_bytes < RANDOM_BYTES) begin
      byte_burst = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 3)       len = 0;
      else if (r < 6)  len = 1;
      else if (r < 10) len = $urandom_range(100, 255);
      else             len = $urandom_range(2, 40);
      fill_record(len);
      // broken records: one byte overwritten, often with zero
      if (len > 0 && $urandom_range(0, 99) < 12)
        rec_bytes[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
      n = (len == 0) ? 1 : len;
      if (len > 2 && $urandom_range(0, 99) < 8) n = $urandom_range(1, len - 1);
      send_record(len, n);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 8'($urandom));
    end
    byte_valid <= 1'b0;

    drain = 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
